[design/bplcr_pkg.sv]
// Shared types and constants for the box position / left-centre-right selector.
`default_nettype none
package bplcr_pkg;

	localparam int DIV_NUM_W = 33;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = 6;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] len;
		logic [DIV_NUM_W-1:0] num;	// left aligned: top len bits are the dividend
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef enum logic [1:0] {
		KIND_POS   = 2'd0,
		KIND_LEFT  = 2'd1,
		KIND_CTR   = 2'd2,
		KIND_RIGHT = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SDIV,
		ST_YDIV,
		ST_MUL,
		ST_XDIV,
		ST_POS,
		ST_LEFT,
		ST_CTR,
		ST_RIGHT
	} state_t;

	localparam logic [2:0] REG_CAM_W    = 3'd0;
	localparam logic [2:0] REG_CAM_H    = 3'd1;
	localparam logic [2:0] REG_LEFT_TH  = 3'd2;
	localparam logic [2:0] REG_RIGHT_TH = 3'd3;
	localparam logic [2:0] REG_CTR_TH   = 3'd4;

	localparam logic [DIV_CNT_W-1:0] LEN_S = 6'd12;
	localparam logic [DIV_CNT_W-1:0] LEN_Y = 6'd18;
	localparam logic [DIV_CNT_W-1:0] LEN_X = 6'd33;

	localparam logic signed [20:0] PICK_INIT_X = 21'sd1000;
	localparam logic [17:0]        PICK_INIT_Y = 18'd1000;
	localparam logic [17:0]        CTR_MISS_Y  = 18'd250;
	localparam logic signed [20:0] POS_X_MAX   = 21'sh0FFFFF;
	localparam logic signed [20:0] POS_X_MIN   = 21'sh100000;
	localparam logic [17:0]        POS_Y_MAX   = 18'd204750;

endpackage
`default_nettype wire

[design/box_position_lcr_select_unit.sv]
// Box ground position estimator with left / centre / right pick selection.
// A new item is accepted only in idle, once all results of the last item are loaded.
// The three divisions (12, 18 and 33 quotient bits) share one bit-serial divider.
// Reset: asynchronous; idles the sequencer, clears output valid and the thresholds,
// and presets the picks and the camera width and height registers.
`default_nettype none
module box_position_lcr_select_unit
	import bplcr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        box_x,
	input  logic [11:0]        box_y,
	input  logic [11:0]        box_width,
	input  logic [11:0]        box_height,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [20:0] pos_x,
	output logic [17:0]        pos_y,
	output logic               last
);

	function automatic logic [20:0] abs21(input logic signed [20:0] v);
		abs21 = v[20] ? (~v + 21'd1) : v;
	endfunction

	state_t state_q, state_d;

	logic [11:0] cam_w_q, cam_h_q;
	logic [19:0] lthr_q, rthr_q, cthr_q;

	logic        fend_q;
	logic [11:0] bh_q;
	logic        d_neg_q;
	logic [12:0] d_mag_q;
	logic [11:0] s_q;
	logic [17:0] y_q;
	logic signed [20:0] x_q;

	logic signed [20:0] lpx_q, rpx_q, cpx_q;
	logic [17:0]        lpy_q, rpy_q, cpy_q;

	logic               out_valid_q;
	kind_t              kind_q;
	logic signed [20:0] pos_x_q;
	logic [17:0]        pos_y_q;
	logic               last_q;

	div_req_t              div_req;
	logic                  div_done;
	logic [DIV_NUM_W-1:0]  div_quo;

	logic out_free;
	logic cap_s, cap_y, cap_x;
	logic out_load, upd_picks, clr_picks;

	// box centre offset, taken at accept
	logic [12:0]        cx;
	logic signed [13:0] dd;
	logic [12:0]        dmag;

	assign cx   = {1'b0, box_x} + {2'b0, box_width[11:1]};
	assign dd   = $signed({1'b0, cx}) - $signed({3'b0, cam_w_q[11:1]});
	assign dmag = dd[13] ? 13'(-dd) : dd[12:0];

	logic [17:0] ch50;
	logic [19:0] s200;
	logic [32:0] prod;

	assign ch50 = {1'b0, cam_h_q, 5'b0} + {2'b0, cam_h_q, 4'b0} + {5'b0, cam_h_q, 1'b0};
	assign s200 = {1'b0, s_q, 7'b0} + {2'b0, s_q, 6'b0} + {5'b0, s_q, 3'b0};
	assign prod = {20'b0, d_mag_q} * {13'b0, s200};

	bplcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SDIV;
			ST_SDIV:  if (div_done) state_d = ST_YDIV;
			ST_YDIV:  if (div_done) state_d = ST_MUL;
			ST_MUL:   state_d = ST_XDIV;
			ST_XDIV:  if (div_done) state_d = ST_POS;
			ST_POS:   if (out_free) state_d = fend_q ? ST_LEFT : ST_IDLE;
			ST_LEFT:  if (out_free) state_d = ST_CTR;
			ST_CTR:   if (out_free) state_d = ST_RIGHT;
			ST_RIGHT: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		div_req     = '0;
		div_req.den = bh_q;
		cap_s       = 1'b0;
		cap_y       = 1'b0;
		cap_x       = 1'b0;
		out_load    = 1'b0;
		upd_picks   = 1'b0;
		clr_picks   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				div_req.start = in_valid;
				div_req.len   = LEN_S;
				div_req.num   = {cam_h_q, 21'b0};
				div_req.den   = box_height;
			end
			ST_SDIV: begin
				cap_s         = div_done;
				div_req.start = div_done;
				div_req.len   = LEN_Y;
				div_req.num   = {ch50, 15'b0};
			end
			ST_YDIV: begin
				cap_y = div_done;
			end
			ST_MUL: begin
				div_req.start = 1'b1;
				div_req.len   = LEN_X;
				div_req.num   = prod;
				div_req.den   = cam_w_q;
			end
			ST_XDIV: begin
				div_req.den = cam_w_q;
				cap_x       = div_done;
			end
			ST_POS: begin
				out_load  = out_free;
				upd_picks = out_free;
			end
			ST_LEFT: begin
				out_load = out_free;
			end
			ST_CTR: begin
				out_load = out_free;
			end
			ST_RIGHT: begin
				out_load  = out_free;
				clr_picks = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_w_q <= 12'd640;
			cam_h_q <= 12'd480;
			lthr_q  <= '0;
			rthr_q  <= '0;
			cthr_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAM_W:    cam_w_q <= cfg_data[11:0];
				REG_CAM_H:    cam_h_q <= cfg_data[11:0];
				REG_LEFT_TH:  lthr_q  <= cfg_data;
				REG_RIGHT_TH: rthr_q  <= cfg_data;
				REG_CTR_TH:   cthr_q  <= cfg_data;
				default:      cam_w_q <= cam_w_q;
			endcase
		end
	end

	// x: signed quotient plus 5, saturated to 21 bits
	logic [34:0] q_ext;
	logic [34:0] xw;
	logic signed [20:0] x_sat;

	assign q_ext = {2'b0, div_quo};
	assign xw    = d_neg_q ? (35'd5 - q_ext) : (q_ext + 35'd5);

	always_comb begin
		if (cam_w_q == 12'd0)
			x_sat = 21'sd5;
		else if (!xw[34] && (|xw[33:20]))
			x_sat = POS_X_MAX;
		else if (xw[34] && !(&xw[33:20]))
			x_sat = POS_X_MIN;
		else
			x_sat = $signed(xw[20:0]);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fend_q  <= frame_end;
			bh_q    <= box_height;
			d_neg_q <= dd[13];
			d_mag_q <= dmag;
		end
		if (cap_s)
			s_q <= (bh_q == 12'd0) ? 12'd0 : div_quo[11:0];
		if (cap_y)
			y_q <= (bh_q == 12'd0) ? 18'd0 : div_quo[17:0];
		if (cap_x)
			x_q <= x_sat;
	end

	// pick update
	logic [21:0] lsum, rdiff;
	logic        is_left, is_right;
	logic [20:0] abs_x;
	logic        is_ctr;

	assign lsum     = {x_q[20], x_q} + {2'b0, lthr_q};
	assign rdiff    = {2'b0, rthr_q} - {x_q[20], x_q};
	assign is_left  = lsum[21];
	assign is_right = rdiff[21];
	assign abs_x    = abs21(x_q);
	assign is_ctr   = (abs_x < {1'b0, cthr_q}) && (abs_x < abs21(cpx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpx_q <= PICK_INIT_X;
			lpy_q <= PICK_INIT_Y;
			rpx_q <= PICK_INIT_X;
			rpy_q <= PICK_INIT_Y;
			cpx_q <= PICK_INIT_X;
			cpy_q <= PICK_INIT_Y;
		end else if (clr_picks) begin
			lpx_q <= PICK_INIT_X;
			lpy_q <= PICK_INIT_Y;
			rpx_q <= PICK_INIT_X;
			rpy_q <= PICK_INIT_Y;
			cpx_q <= PICK_INIT_X;
			cpy_q <= PICK_INIT_Y;
		end else if (upd_picks) begin
			if (is_left) begin
				if (lpy_q > y_q) begin
					lpx_q <= x_q;
					lpy_q <= y_q;
				end
			end else if (is_right) begin
				if (rpy_q > y_q) begin
					rpx_q <= x_q;
					rpy_q <= y_q;
				end
			end
			if (is_ctr) begin
				cpx_q <= x_q;
				cpy_q <= y_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			case (state_q)
				ST_POS: begin
					kind_q  <= KIND_POS;
					pos_x_q <= x_q;
					pos_y_q <= y_q;
					last_q  <= !fend_q;
				end
				ST_LEFT: begin
					kind_q  <= KIND_LEFT;
					pos_x_q <= lpx_q;
					pos_y_q <= lpy_q;
					last_q  <= 1'b0;
				end
				ST_CTR: begin
					kind_q <= KIND_CTR;
					last_q <= 1'b0;
					// no centre found this frame
					if (cpx_q == PICK_INIT_X) begin
						pos_x_q <= '0;
						pos_y_q <= CTR_MISS_Y;
					end else begin
						pos_x_q <= cpx_q;
						pos_y_q <= cpy_q;
					end
				end
				default: begin
					kind_q  <= KIND_RIGHT;
					pos_x_q <= rpx_q;
					pos_y_q <= rpy_q;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign last      = last_q;

endmodule
`default_nettype wire

[design/bplcr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module bplcr_div
	import bplcr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] sh_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, sh_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, req.den};
	assign diff  = trial - {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// divisor is held stable by the sequencer for the whole run
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			sh_q  <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			sh_q  <= {sh_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule
`default_nettype wire

[design/bplcr_chk.sv]
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module bplcr_chk
	import bplcr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         kind,
	input logic signed [20:0] pos_x,
	input logic [17:0]        pos_y,
	input logic               last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pos_x))
		else $error("result item dropped or changed while stalled");

	a_pick_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_POS) |-> (last == (kind == KIND_RIGHT)))
		else $error("last flag wrong on a pick item");

	a_ctr_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CTR) |-> (pos_x != PICK_INIT_X))
		else $error("unfound centre pick not substituted");

	a_pos_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_POS) |-> (pos_y <= POS_Y_MAX))
		else $error("position y out of range");

endmodule

bind box_position_lcr_select_unit bplcr_chk u_bplcr_chk (.*);
`default_nettype wire
